[design/lfpd_pkg.sv]
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared constants and the drive clamp for the line-follow PD steering core.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BASE_DRIVE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_OFFSET    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_OFFSET   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DIFF_GAIN      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_FORWARD = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_REVERSE = 3'd6;

  localparam logic        [11:0] BASE_DRIVE_RST     = 12'd500;
  localparam logic signed [12:0] OFFSET_RST         = 13'sd0;
  localparam logic        [15:0] PROP_GAIN_RST      = 16'd256;
  localparam logic        [15:0] DIFF_GAIN_RST      = 16'd0;
  localparam logic signed [12:0] SEARCH_FORWARD_RST = 13'sd1000;
  localparam logic signed [12:0] SEARCH_REVERSE_RST = -13'sd400;

  localparam logic [9:0] WEIGHT_INNER  = 10'd80;
  localparam logic [9:0] WEIGHT_MIDDLE = 10'd180;
  localparam logic [9:0] WEIGHT_OUTER  = 10'd400;

  localparam logic signed [21:0] DRIVE_MAX = 22'sd3000;
  localparam logic signed [21:0] DRIVE_MIN = -22'sd1000;

  localparam logic [1:0] SIDE_STRAIGHT = 2'd0;
  localparam logic [1:0] SIDE_LEFT     = 2'd1;
  localparam logic [1:0] SIDE_RIGHT    = 2'd2;

  localparam logic [1:0] LOCK_NONE  = 2'd0;
  localparam logic [1:0] LOCK_LEFT  = 2'd1;
  localparam logic [1:0] LOCK_RIGHT = 2'd2;

  function automatic logic signed [13:0] clamp_drive(input logic signed [21:0] v);
    logic signed [21:0] r;
    if (v > DRIVE_MAX) begin
      r = DRIVE_MAX;
    end else if (v < DRIVE_MIN) begin
      r = DRIVE_MIN;
    end else begin
      r = v;
    end
    return r[13:0];
  endfunction

endpackage

`default_nettype wire

[design/line_follow_pd_steering_core.sv]
// ----------------------------------------------------------------------------
// line_follow_pd_steering_core
// Eight-sensor line follower with PD wheel steering and lost-line search.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready): one beat per control tick, carrying
//     action (0 tick, 1 clear controller state) and sensor_bits.
//   out channel (out_valid/out_ready): one beat per input beat, in order,
//     carrying left_drive, right_drive, line_lost and turn_side.
//   cfg channel (cfg_valid/cfg_ready): register writes, always ready; write
//     only while no beat is in flight.
// Pipeline: error forming and state update at accept, gain multiplies in
// the second stage, sum, clamp and output select in the third, whose
// register drives out_valid. Throughput is one beat per cycle while the
// receiver does not stall; the turn lock and previous error live in one
// register loop updated at accept.
// When the receiver stalls, beats hold in the stages and in_ready drops
// once all three are full. rst clears the pipeline, the controller state
// and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_pd_steering_core (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst,
  input  wire  logic                                 in_valid,
  output logic                                       in_ready,
  input  wire  logic                                 action,
  input  wire  logic [7:0]                           sensor_bits,
  output logic                                       out_valid,
  input  wire  logic                                 out_ready,
  output logic signed [13:0]                         left_drive,
  output logic signed [13:0]                         right_drive,
  output logic                                       line_lost,
  output logic [1:0]                                 turn_side,
  input  wire  logic                                 cfg_valid,
  output logic                                       cfg_ready,
  input  wire  logic [lfpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  logic [lfpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration
  logic        [11:0] base_drive;
  logic signed [12:0] left_offset;
  logic signed [12:0] right_offset;
  logic        [15:0] prop_gain;
  logic        [15:0] diff_gain;
  logic signed [12:0] search_forward;
  logic signed [12:0] search_reverse;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_drive     <= lfpd_pkg::BASE_DRIVE_RST;
      left_offset    <= lfpd_pkg::OFFSET_RST;
      right_offset   <= lfpd_pkg::OFFSET_RST;
      prop_gain      <= lfpd_pkg::PROP_GAIN_RST;
      diff_gain      <= lfpd_pkg::DIFF_GAIN_RST;
      search_forward <= lfpd_pkg::SEARCH_FORWARD_RST;
      search_reverse <= lfpd_pkg::SEARCH_REVERSE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfpd_pkg::REG_BASE_DRIVE:     base_drive     <= cfg_data[11:0];
        lfpd_pkg::REG_LEFT_OFFSET:    left_offset    <= $signed(cfg_data[12:0]);
        lfpd_pkg::REG_RIGHT_OFFSET:   right_offset   <= $signed(cfg_data[12:0]);
        lfpd_pkg::REG_PROP_GAIN:      prop_gain      <= cfg_data;
        lfpd_pkg::REG_DIFF_GAIN:      diff_gain      <= cfg_data;
        lfpd_pkg::REG_SEARCH_FORWARD: search_forward <= $signed(cfg_data[12:0]);
        lfpd_pkg::REG_SEARCH_REVERSE: search_reverse <= $signed(cfg_data[12:0]);
        default: ;
      endcase
    end
  end

  // pipeline flow
  logic a_valid;
  logic b_valid;
  logic c_free;
  logic b_free;
  logic a_free;
  logic in_fire;

  assign c_free   = !out_valid || out_ready;
  assign b_free   = !b_valid || c_free;
  assign a_free   = !a_valid || b_free;
  assign in_ready = a_free;
  assign in_fire  = in_valid && in_ready;

  // controller state; right error is always the negated left error
  logic signed [10:0] prev_err;
  logic        [1:0]  side;
  logic        [1:0]  lock;

  logic        [1:0]  lock_eff;
  logic        [1:0]  lock_mid;
  logic        [1:0]  lock_next;
  logic        [1:0]  side_next;
  logic               left_en;
  logic               right_en;
  logic        [9:0]  left_sum;
  logic        [9:0]  right_sum;
  logic signed [10:0] err;
  logic signed [11:0] err_diff;

  always_comb begin
    lock_eff  = (|sensor_bits[5:2]) ? lfpd_pkg::LOCK_NONE : lock;
    side_next = side;
    left_en   = (lock_eff != lfpd_pkg::LOCK_RIGHT);
    left_sum  = 10'd0;
    lock_mid  = lock_eff;
    if (left_en) begin
      left_sum = (sensor_bits[5] ? lfpd_pkg::WEIGHT_INNER  : 10'd0)
               + (sensor_bits[6] ? lfpd_pkg::WEIGHT_MIDDLE : 10'd0)
               + (sensor_bits[7] ? lfpd_pkg::WEIGHT_OUTER  : 10'd0);
      if (sensor_bits[7]) begin
        side_next = lfpd_pkg::SIDE_LEFT;
        lock_mid  = lfpd_pkg::LOCK_LEFT;
      end
    end
    right_en  = (lock_mid != lfpd_pkg::LOCK_LEFT);
    right_sum = 10'd0;
    lock_next = lock_mid;
    if (right_en) begin
      right_sum = (sensor_bits[2] ? lfpd_pkg::WEIGHT_INNER  : 10'd0)
                + (sensor_bits[1] ? lfpd_pkg::WEIGHT_MIDDLE : 10'd0)
                + (sensor_bits[0] ? lfpd_pkg::WEIGHT_OUTER  : 10'd0);
      if (sensor_bits[0]) begin
        side_next = lfpd_pkg::SIDE_RIGHT;
        lock_next = lfpd_pkg::LOCK_RIGHT;
      end
    end
    err      = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    err_diff = 12'(err) - 12'(prev_err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= 11'sd0;
      side     <= lfpd_pkg::SIDE_STRAIGHT;
      lock     <= lfpd_pkg::LOCK_NONE;
    end else if (in_fire) begin
      if (action) begin
        prev_err <= 11'sd0;
        side     <= lfpd_pkg::SIDE_STRAIGHT;
        lock     <= lfpd_pkg::LOCK_NONE;
      end else begin
        prev_err <= err;
        side     <= side_next;
        lock     <= lock_next;
      end
    end
  end

  // stage A: formed error
  logic               a_clr;
  logic               a_lost;
  logic        [1:0]  a_side;
  logic signed [10:0] a_err;
  logic signed [11:0] a_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_clr  <= action;
      a_lost <= (sensor_bits == 8'd0);
      a_side <= side_next;
      a_err  <= err;
      a_diff <= err_diff;
    end
  end

  // stage B: gain products
  logic               b_clr;
  logic               b_lost;
  logic        [1:0]  b_side;
  logic signed [27:0] b_pp;
  logic signed [28:0] b_dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_free) begin
      b_clr  <= a_clr;
      b_lost <= a_lost;
      b_side <= a_side;
      b_pp   <= $signed({1'b0, prop_gain}) * a_err;
      b_dp   <= $signed({1'b0, diff_gain}) * a_diff;
    end
  end

  // stage C: truncate toward zero, sum, clamp, select
  logic signed [27:0] pp_adj;
  logic signed [28:0] dp_adj;
  logic signed [19:0] p_term;
  logic signed [20:0] d_term;
  logic signed [13:0] left_base;
  logic signed [13:0] right_base;
  logic signed [21:0] left_sum_c;
  logic signed [21:0] right_sum_c;
  logic signed [13:0] left_drive_next;
  logic signed [13:0] right_drive_next;
  logic               line_lost_next;
  logic        [1:0]  turn_side_next;

  always_comb begin
    pp_adj      = b_pp + $signed({20'd0, {8{b_pp[27]}}});
    dp_adj      = b_dp + $signed({21'd0, {8{b_dp[28]}}});
    p_term      = $signed(pp_adj[27:8]);
    d_term      = $signed(dp_adj[28:8]);
    left_base   = $signed({2'b00, base_drive}) + 14'(left_offset);
    right_base  = $signed({2'b00, base_drive}) + 14'(right_offset);
    left_sum_c  = 22'(left_base) + 22'(p_term) + 22'(d_term);
    right_sum_c = 22'(right_base) - 22'(p_term) - 22'(d_term);

    line_lost_next = b_lost;
    turn_side_next = b_side;
    if (b_clr) begin
      left_drive_next  = 14'sd0;
      right_drive_next = 14'sd0;
      line_lost_next   = 1'b0;
      turn_side_next   = lfpd_pkg::SIDE_STRAIGHT;
    end else if (b_lost) begin
      unique case (b_side)
        lfpd_pkg::SIDE_LEFT: begin
          left_drive_next  = 14'(search_reverse);
          right_drive_next = 14'(search_forward);
        end
        lfpd_pkg::SIDE_RIGHT: begin
          left_drive_next  = 14'(search_forward);
          right_drive_next = 14'(search_reverse);
        end
        default: begin
          left_drive_next  = left_base;
          right_drive_next = right_base;
        end
      endcase
    end else begin
      left_drive_next  = lfpd_pkg::clamp_drive(left_sum_c);
      right_drive_next = lfpd_pkg::clamp_drive(right_sum_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_free) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_free) begin
      left_drive  <= left_drive_next;
      right_drive <= right_drive_next;
      line_lost   <= line_lost_next;
      turn_side   <= turn_side_next;
    end
  end

endmodule

`default_nettype wire

[bench/line_follow_pd_steering_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follow_pd_steering_core_tb
// Self-checking bench for the line-follow PD steering core. A directed table
// walks sensor patterns, turn locks, lost-line search and clamping; random
// phases then reload every register and stream sensor sweeps, lost-line gaps,
// noise and state clears under random valid/ready gaps. Each output beat is
// compared with its typed table value, else a cycle-free steering predictor.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_core_tb;

  localparam int PIPE_LAT   = 3;
  localparam int PHASES     = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int DIR_ROWS   = 32;

  localparam int BIT_L3 = 7;
  localparam int BIT_L2 = 6;
  localparam int BIT_L1 = 5;
  localparam int BIT_R1 = 2;
  localparam int BIT_R2 = 1;
  localparam int BIT_R3 = 0;
  localparam logic [7:0] INNER_MASK = 8'h3C;

  localparam longint W_INNER  = 80;
  localparam longint W_MIDDLE = 180;
  localparam longint W_OUTER  = 400;
  localparam longint CLIP_HI  = 3000;
  localparam longint CLIP_LO  = -1000;

  typedef enum logic {ACT_TICK = 1'b0, ACT_CLEAR = 1'b1} act_e;
  typedef enum logic {ROW_ITEM = 1'b0, ROW_WRITE = 1'b1} row_kind_e;

  typedef struct packed {
    logic signed [13:0] left;
    logic signed [13:0] right;
    logic               lost;
    logic [1:0]         side;
  } drive_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [15:0] data;
    act_e        act;
    logic [7:0]  sens;
    logic        typed;
    drive_t      want;
  } step_row_t;

  localparam drive_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic action = 1'b0;
  logic [7:0] sensor_bits = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [13:0] left_drive;
  logic signed [13:0] right_drive;
  logic line_lost;
  logic [1:0] turn_side;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lfpd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  line_follow_pd_steering_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .sensor_bits (sensor_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .line_lost   (line_lost),
    .turn_side   (turn_side),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow, reset values
  logic [11:0]        base_q = 12'd500;
  logic signed [12:0] loff_q = 13'sd0;
  logic signed [12:0] roff_q = 13'sd0;
  logic [15:0]        kp_q   = 16'd256;
  logic [15:0]        kd_q   = 16'd0;
  logic signed [12:0] sfwd_q = 13'sd1000;
  logic signed [12:0] srev_q = -13'sd400;

  // controller state
  longint     prev_le = 0;
  longint     prev_re = 0;
  logic [1:0] side_q  = lfpd_pkg::SIDE_STRAIGHT;
  logic [1:0] lock_q  = lfpd_pkg::LOCK_NONE;

  drive_t drive_q [$];
  bit     quiet = 1'b0;
  int     mismatches = 0;
  int     beats_checked = 0;
  int     lost_beats = 0;
  int     clears = 0;
  int     settings_loaded = 0;

  logic [2:0] reg_ids [7] = '{lfpd_pkg::REG_BASE_DRIVE, lfpd_pkg::REG_LEFT_OFFSET,
                              lfpd_pkg::REG_RIGHT_OFFSET, lfpd_pkg::REG_PROP_GAIN,
                              lfpd_pkg::REG_DIFF_GAIN, lfpd_pkg::REG_SEARCH_FORWARD,
                              lfpd_pkg::REG_SEARCH_REVERSE};
  int reg_lo [7] = '{0, -3200, -3200, 0, 0, -3200, -3200};
  int reg_hi [7] = '{3200, 3200, 3200, 65535, 65535, 3200, 3200};

  step_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_ITEM, 3'd0, 16'd0, ACT_CLEAR, 8'h00, 1'b1,
      '{14'sd0, 14'sd0, 1'b0, lfpd_pkg::SIDE_STRAIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h00, 1'b1,
      '{14'sd500, 14'sd500, 1'b1, lfpd_pkg::SIDE_STRAIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h18, 1'b1,
      '{14'sd500, 14'sd500, 1'b0, lfpd_pkg::SIDE_STRAIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h20, 1'b1,
      '{14'sd420, 14'sd580, 1'b0, lfpd_pkg::SIDE_STRAIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h40, 1'b0, NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h80, 1'b1,
      '{14'sd100, 14'sd900, 1'b0, lfpd_pkg::SIDE_LEFT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h00, 1'b1,
      '{-14'sd400, 14'sd1000, 1'b1, lfpd_pkg::SIDE_LEFT}},
    // left lock hides the outer right sensor
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h01, 1'b1,
      '{14'sd500, 14'sd500, 1'b0, lfpd_pkg::SIDE_LEFT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h04, 1'b1,
      '{14'sd580, 14'sd420, 1'b0, lfpd_pkg::SIDE_LEFT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h01, 1'b1,
      '{14'sd900, 14'sd100, 1'b0, lfpd_pkg::SIDE_RIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h80, 1'b1,
      '{14'sd500, 14'sd500, 1'b0, lfpd_pkg::SIDE_RIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h00, 1'b1,
      '{14'sd1000, -14'sd400, 1'b1, lfpd_pkg::SIDE_RIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'hFF, 1'b1,
      '{-14'sd160, 14'sd1160, 1'b0, lfpd_pkg::SIDE_LEFT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_CLEAR, 8'hFF, 1'b1,
      '{14'sd0, 14'sd0, 1'b0, lfpd_pkg::SIDE_STRAIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h81, 1'b1,
      '{14'sd100, 14'sd900, 1'b0, lfpd_pkg::SIDE_LEFT}},
    '{ROW_WRITE, lfpd_pkg::REG_PROP_GAIN, 16'hFFFF, ACT_TICK, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h80, 1'b1,
      '{-14'sd1000, 14'sd3000, 1'b0, lfpd_pkg::SIDE_LEFT}},
    '{ROW_WRITE, lfpd_pkg::REG_DIFF_GAIN, 16'hFFFF, ACT_TICK, 8'h00, 1'b0, NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h01, 1'b0, NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h7E, 1'b0, NO_WANT},
    '{ROW_WRITE, lfpd_pkg::REG_BASE_DRIVE, 16'd3200, ACT_TICK, 8'h00, 1'b0, NO_WANT},
    // -3200
    '{ROW_WRITE, lfpd_pkg::REG_LEFT_OFFSET, 16'hF380, ACT_TICK, 8'h00, 1'b0, NO_WANT},
    '{ROW_WRITE, lfpd_pkg::REG_RIGHT_OFFSET, 16'd3200, ACT_TICK, 8'h00, 1'b0, NO_WANT},
    // -3200
    '{ROW_WRITE, lfpd_pkg::REG_SEARCH_FORWARD, 16'hF380, ACT_TICK, 8'h00, 1'b0,
      NO_WANT},
    '{ROW_WRITE, lfpd_pkg::REG_SEARCH_REVERSE, 16'd3200, ACT_TICK, 8'h00, 1'b0,
      NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_CLEAR, 8'h00, 1'b1,
      '{14'sd0, 14'sd0, 1'b0, lfpd_pkg::SIDE_STRAIGHT}},
    // straight search drive is not clamped
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h00, 1'b1,
      '{14'sd0, 14'sd6400, 1'b1, lfpd_pkg::SIDE_STRAIGHT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h02, 1'b0, NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h80, 1'b0, NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h00, 1'b1,
      '{14'sd3200, -14'sd3200, 1'b1, lfpd_pkg::SIDE_LEFT}},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'h55, 1'b0, NO_WANT},
    '{ROW_ITEM, 3'd0, 16'd0, ACT_TICK, 8'hAA, 1'b0, NO_WANT}
  };

  function automatic longint clip_drive(input longint v);
    if (v > CLIP_HI) return CLIP_HI;
    if (v < CLIP_LO) return CLIP_LO;
    return v;
  endfunction

  function automatic drive_t steer_predict(input act_e a, input logic [7:0] s);
    drive_t r;
    longint le, re, ld, rd;
    logic   lost;
    le = 0;
    re = 0;
    if (a == ACT_CLEAR) begin
      prev_le = 0;
      prev_re = 0;
      side_q  = lfpd_pkg::SIDE_STRAIGHT;
      lock_q  = lfpd_pkg::LOCK_NONE;
      return '0;
    end
    if ((s & INNER_MASK) != 8'h00) lock_q = lfpd_pkg::LOCK_NONE;
    if (lock_q != lfpd_pkg::LOCK_RIGHT) begin
      if (s[BIT_L1]) begin le -= W_INNER;  re += W_INNER;  end
      if (s[BIT_L2]) begin le -= W_MIDDLE; re += W_MIDDLE; end
      if (s[BIT_L3]) begin
        le -= W_OUTER;
        re += W_OUTER;
        side_q = lfpd_pkg::SIDE_LEFT;
        lock_q = lfpd_pkg::LOCK_LEFT;
      end
    end
    if (lock_q != lfpd_pkg::LOCK_LEFT) begin
      if (s[BIT_R1]) begin le += W_INNER;  re -= W_INNER;  end
      if (s[BIT_R2]) begin le += W_MIDDLE; re -= W_MIDDLE; end
      if (s[BIT_R3]) begin
        le += W_OUTER;
        re -= W_OUTER;
        side_q = lfpd_pkg::SIDE_RIGHT;
        lock_q = lfpd_pkg::LOCK_RIGHT;
      end
    end
    lost = (s == 8'h00);
    if (lost) begin
      if (side_q == lfpd_pkg::SIDE_LEFT) begin
        ld = longint'(srev_q);
        rd = longint'(sfwd_q);
      end else if (side_q == lfpd_pkg::SIDE_RIGHT) begin
        ld = longint'(sfwd_q);
        rd = longint'(srev_q);
      end else begin
        ld = longint'(base_q) + longint'(loff_q);
        rd = longint'(base_q) + longint'(roff_q);
      end
    end else begin
      ld = clip_drive(longint'(base_q) + longint'(loff_q) + (longint'(kp_q) * le) / 256
                      + (longint'(kd_q) * (le - prev_le)) / 256);
      rd = clip_drive(longint'(base_q) + longint'(roff_q) + (longint'(kp_q) * re) / 256
                      + (longint'(kd_q) * (re - prev_re)) / 256);
    end
    prev_le = le;
    prev_re = re;
    r.left  = ld[13:0];
    r.right = rd[13:0];
    r.lost  = lost;
    r.side  = side_q;
    return r;
  endfunction

  task automatic send_beat(input act_e a, input logic [7:0] s);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= a;
    sensor_bits <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic issue(input act_e a, input logic [7:0] s, input logic typed,
                       input drive_t typed_want);
    drive_t want;
    send_beat(a, s);
    want = steer_predict(a, s);
    if (typed) want = typed_want;
    if (a == ACT_CLEAR) clears++;
    drive_q.push_back(want);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [15:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lfpd_pkg::REG_BASE_DRIVE:     base_q = d[11:0];
      lfpd_pkg::REG_LEFT_OFFSET:    loff_q = d[12:0];
      lfpd_pkg::REG_RIGHT_OFFSET:   roff_q = d[12:0];
      lfpd_pkg::REG_PROP_GAIN:      kp_q   = d;
      lfpd_pkg::REG_DIFF_GAIN:      kd_q   = d;
      lfpd_pkg::REG_SEARCH_FORWARD: sfwd_q = d[12:0];
      lfpd_pkg::REG_SEARCH_REVERSE: srev_q = d[12:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // phase 0 loads every low bound, phase 1 every high bound
  task automatic load_regs(input int phase);
    int k, v, roll, top;
    for (k = 0; k < 7; k++) begin
      top = reg_hi[k];
      if ((reg_ids[k] == lfpd_pkg::REG_PROP_GAIN || reg_ids[k] == lfpd_pkg::REG_DIFF_GAIN)
          && $urandom_range(1))
        top = 1023;
      roll = $urandom_range(9);
      if (phase == 0) v = reg_lo[k];
      else if (phase == 1) v = reg_hi[k];
      else if (roll == 0) v = reg_lo[k];
      else if (roll == 1) v = reg_hi[k];
      else v = reg_lo[k] + int'($urandom_range(top - reg_lo[k]));
      reg_write(reg_ids[k], 16'(v));
    end
    settings_loaded++;
  endtask

  task automatic flag_field(input string name, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    mismatches++;
  endtask

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin : check_blk
    drive_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, actual %0d/%0d", $time,
                 left_drive, right_drive);
        mismatches++;
      end else begin
        want = drive_q.pop_front();
        beats_checked++;
        if (line_lost) lost_beats++;
        if (left_drive !== want.left) flag_field("left_drive", want.left, left_drive);
        if (right_drive !== want.right) flag_field("right_drive", want.right, right_drive);
        if (line_lost !== want.lost) flag_field("line_lost", want.lost, line_lost);
        if (turn_side !== want.side) flag_field("turn_side", want.side, turn_side);
      end
    end
  end

  initial begin : stim
    step_row_t  row;
    act_e       a;
    logic [7:0] s;
    int         i, ph, n, roll, run, pos;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      row = dir_tab[i];
      if (row.kind == ROW_WRITE) begin
        drain();
        reg_write(row.idx, row.data);
      end else begin
        issue(row.act, row.sens, row.typed, row.want);
      end
    end
    settings_loaded++;

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      load_regs(ph);
      quiet = (ph == 5);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        roll = $urandom_range(99);
        a = ACT_TICK;
        if (roll < 4) begin
          a = ACT_CLEAR;
          s = 8'($urandom_range(255));
        end else if (roll < 64) begin
          // contiguous run of one to three sensors, as a real line looks
          run = $urandom_range(3, 1);
          pos = $urandom_range(8 - run);
          s = 8'(((1 << run) - 1) << pos);
        end else if (roll < 79) begin
          s = 8'h00;
        end else begin
          s = 8'($urandom_range(255));
        end
        issue(a, s, 1'b0, NO_WANT);
      end
    end
    quiet = 1'b0;
    drain();

    $display("covered %0d output beats across %0d register settings", beats_checked,
             settings_loaded);
    $display("with %0d lost-line beats, %0d state clears, %0d mismatches", lost_beats,
             clears, mismatches);
    if (mismatches == 0) begin
      $display("line_follow_pd_steering_core_tb: clean");
    end else begin
      $display("line_follow_pd_steering_core_tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d beats outstanding", drive_q.size());
    $display("line_follow_pd_steering_core_tb: errors");
    $finish;
  end

endmodule

[files.f]
design/lfpd_pkg.sv
design/line_follow_pd_steering_core.sv
bench/line_follow_pd_steering_core_tb.sv
